FILE: rtl/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg: shared types and constants for the palette scanline scaler
// Field widths, command codes, result record and parameter defaults.
// ----------------------------------------------------------------------------
package pss_pkg;

  // Field widths of one input beat
  localparam int CMD_W   = 2;
  localparam int INDEX_W = 8;
  localparam int COLOR_W = 16;
  localparam int POS_W   = 16;
  localparam int CODE_W  = 8;

  // Field widths of one result beat
  localparam int RECT_X_W = 9;
  localparam int RECT_Y_W = 8;
  localparam int SIZE_W   = 7;

  // Scale register
  localparam int SCALE_W = 7;
  localparam logic [SCALE_W-1:0] MAX_SCALE = 7'd100;

  // Character codes from this one up select a palette colour
  localparam logic [CODE_W-1:0] FIRST_COLOR_CODE = 8'd33;

  // Colour of a palette entry that was never written or lies outside the table
  localparam logic [COLOR_W-1:0] BLANK_COLOR = 16'hFFFF;

  // Parameter defaults
  localparam int SCREEN_W_DEF    = 320;
  localparam int SCREEN_H_DEF    = 240;
  localparam int TABLE_DEPTH_DEF = 223;

  typedef enum logic [CMD_W-1:0] {
    CMD_PAL_WR  = 2'd0,
    CMD_SET_POS = 2'd1,
    CMD_CHAR    = 2'd2,
    CMD_EOL     = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [RECT_X_W-1:0] rect_x;
    logic [RECT_Y_W-1:0] rect_y;
    logic [SIZE_W-1:0]   rect_width;
    logic [SIZE_W-1:0]   rect_height;
    logic [COLOR_W-1:0]  rect_color;
  } rect_t;

endpackage

FILE: rtl/pss_if.sv
// ----------------------------------------------------------------------------
// pss channel interfaces
// Valid/ready channels for command beats in and rectangle beats out.
// ----------------------------------------------------------------------------
interface pss_item_if;
  logic                                valid;
  logic                                ready;
  logic        [pss_pkg::CMD_W-1:0]    cmd;
  logic        [pss_pkg::INDEX_W-1:0]  palette_index;
  logic        [pss_pkg::COLOR_W-1:0]  palette_color;
  logic signed [pss_pkg::POS_W-1:0]    pos_x;
  logic signed [pss_pkg::POS_W-1:0]    pos_y;
  logic        [pss_pkg::CODE_W-1:0]   char_code;

  modport source (
    output valid, cmd, palette_index, palette_color, pos_x, pos_y, char_code,
    input  ready
  );
  modport sink (
    input  valid, cmd, palette_index, palette_color, pos_x, pos_y, char_code,
    output ready
  );
endinterface

interface pss_rect_if;
  logic                            valid;
  logic                            ready;
  logic [pss_pkg::RECT_X_W-1:0]    rect_x;
  logic [pss_pkg::RECT_Y_W-1:0]    rect_y;
  logic [pss_pkg::SIZE_W-1:0]      rect_width;
  logic [pss_pkg::SIZE_W-1:0]      rect_height;
  logic [pss_pkg::COLOR_W-1:0]     rect_color;

  modport source (
    output valid, rect_x, rect_y, rect_width, rect_height, rect_color,
    input  ready
  );
  modport sink (
    input  valid, rect_x, rect_y, rect_width, rect_height, rect_color,
    output ready
  );
endinterface

FILE: rtl/palette_scanline_scaler_unit.sv
// A rectangle is registered in the capture stage and then in the result buffer before it reaches the output.
// Throughput: one command beat per cycle while ready is high; a three-entry result buffer absorbs output stalls.
// Input ready drops only when buffered plus in-flight rectangles reach the buffer depth.
// Reset (synchronous, active high) sets scale to 1, position and cursor to zero, and
// clears the palette valid bits so every entry reads as white (0xFFFF) until written.
// ----------------------------------------------------------------------------
// palette_scanline_scaler_unit
// Expands palette-coded scanline characters into scaled, screen-clipped
// rectangles: one palette read and a few compares per character.
// ----------------------------------------------------------------------------
module palette_scanline_scaler_unit #(
  parameter int SCREEN_W    = pss_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H    = pss_pkg::SCREEN_H_DEF,
  parameter int TABLE_DEPTH = pss_pkg::TABLE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [pss_pkg::SCALE_W-1:0]  cfg_data,
  pss_item_if.sink                     item,
  pss_rect_if.source                   rect
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int XW    = $clog2(SCREEN_W + 1);
  localparam int YW    = $clog2(SCREEN_H + 1);
  localparam int QD    = 3;

  localparam logic signed [17:0] W_X = 18'(SCREEN_W);
  localparam logic signed [16:0] H_Y = 17'(SCREEN_H);
  localparam logic        [8:0]  DEPTH_L = 9'(TABLE_DEPTH);
  localparam logic        [1:0]  Q_FULL  = 2'(QD);
  localparam logic        [1:0]  Q_LAST  = 2'(QD - 1);

  // Architectural state
  logic        [pss_pkg::SCALE_W-1:0] scale;
  logic signed [15:0]                 line_start_x, line_start_x_next;
  logic signed [15:0]                 row_y, row_y_next;
  logic signed [16:0]                 cursor_x, cursor_x_next;

  // Palette store and its valid bits
  logic [pss_pkg::COLOR_W-1:0] pal_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]      pal_valid;

  // Stage after acceptance
  logic                         p_valid;
  logic [XW-1:0]                p_x_lo, p_x_end;
  logic [YW-1:0]                p_y_lo, p_y_hi;
  logic                         p_hit;
  logic [pss_pkg::COLOR_W-1:0]  p_color;

  // Result buffer
  pss_pkg::rect_t  q_mem [QD];
  logic [1:0]      q_head, q_tail, q_count;
  pss_pkg::rect_t  q_in;

  logic            item_fire, rect_fire;
  pss_pkg::cmd_t   cmd;

  assign cmd       = pss_pkg::cmd_t'(item.cmd);
  assign item_fire = item.valid && item.ready;
  assign rect_fire = rect.valid && rect.ready;

  // Take a beat while buffer plus in-flight rectangles leave room
  assign item.ready = ({1'b0, q_count} + {2'b00, p_valid}) < 3'(QD);

  // Horizontal span of the character cell
  logic signed [7:0]  scale_s;
  logic signed [17:0] x_sum, x_end;
  logic signed [16:0] cx_lo;
  logic               x_on;

  assign scale_s = signed'({1'b0, scale});
  assign x_sum   = 18'(cursor_x) + 18'(scale_s);
  assign x_end   = (x_sum < W_X) ? x_sum : W_X;
  assign cx_lo   = cursor_x[16] ? 17'sd0 : cursor_x;
  assign x_on    = 18'(cursor_x) < W_X;

  // Vertical span of the character cell
  logic signed [16:0] y_sum, y_hi;
  logic signed [15:0] y_lo;

  assign y_sum = 17'(row_y) + 17'(scale_s);
  assign y_hi  = (y_sum < H_Y) ? y_sum : H_Y;
  assign y_lo  = row_y[15] ? 16'sd0 : row_y;

  logic is_color, cell_vis;

  assign is_color = item.char_code >= pss_pkg::FIRST_COLOR_CODE;
  assign cell_vis = (18'(cx_lo) < x_end) && (17'(y_lo) < y_hi);

  // Row advance at end of line: step by the scale, clamp to one past the bottom, and step by one once at or past it
  logic signed [16:0] eol_row;

  always_comb begin
    if (17'(row_y) >= H_Y) begin
      eol_row = 17'(row_y) + 17'sd1;
    end else if (y_sum > H_Y) begin
      eol_row = H_Y + 17'sd1;
    end else begin
      eol_row = y_sum;
    end
  end

  // Palette addressing
  logic [pss_pkg::CODE_W-1:0] entry;
  logic                       wr_ok, rd_ok;

  assign entry = item.char_code - pss_pkg::FIRST_COLOR_CODE;
  assign wr_ok = {1'b0, item.palette_index} < DEPTH_L;
  assign rd_ok = is_color && ({1'b0, entry} < DEPTH_L);

  // Next state of position registers and whether a rectangle is due
  logic rect_due;

  always_comb begin
    line_start_x_next = line_start_x;
    row_y_next        = row_y;
    cursor_x_next     = cursor_x;
    rect_due          = 1'b0;
    if (item_fire) begin
      unique case (cmd)
        pss_pkg::CMD_PAL_WR: begin
          rect_due = 1'b0;
        end
        pss_pkg::CMD_SET_POS: begin
          line_start_x_next = item.pos_x;
          cursor_x_next     = 17'(item.pos_x);
          row_y_next        = item.pos_y;
        end
        pss_pkg::CMD_CHAR: begin
          if (!is_color) begin
            cursor_x_next = 17'(x_end);
          end else if (x_on) begin
            cursor_x_next = 17'(x_end);
            rect_due      = cell_vis;
          end
        end
        pss_pkg::CMD_EOL: begin
          cursor_x_next = 17'(line_start_x);
          row_y_next    = 16'(eol_row);
        end
        default: begin
          rect_due = 1'b0;
        end
      endcase
    end
  end

  // Hold control state and scale
  always_ff @(posedge clk) begin
    if (rst) begin
      scale        <= pss_pkg::SCALE_W'(1);
      line_start_x <= '0;
      row_y        <= '0;
      cursor_x     <= '0;
      pal_valid    <= '0;
      p_valid      <= 1'b0;
    end else begin
      if (cfg_we && cfg_data != '0 && cfg_data <= pss_pkg::MAX_SCALE) begin
        scale <= cfg_data;
      end
      line_start_x <= line_start_x_next;
      row_y        <= row_y_next;
      cursor_x     <= cursor_x_next;
      if (item_fire && cmd == pss_pkg::CMD_PAL_WR && wr_ok) begin
        pal_valid[item.palette_index[IDX_W-1:0]] <= 1'b1;
      end
      p_valid <= rect_due;
    end
  end

  // Palette memory: write on a palette beat, registered read on every beat
  always_ff @(posedge clk) begin
    if (item_fire && cmd == pss_pkg::CMD_PAL_WR && wr_ok) begin
      pal_mem[item.palette_index[IDX_W-1:0]] <= item.palette_color;
    end
    if (item_fire) begin
      p_color <= pal_mem[entry[IDX_W-1:0]];
    end
  end

  // Capture clipped bounds and palette hit
  always_ff @(posedge clk) begin
    if (item_fire) begin
      p_x_lo  <= XW'(cx_lo);
      p_x_end <= XW'(x_end);
      p_y_lo  <= YW'(y_lo);
      p_y_hi  <= YW'(y_hi);
      p_hit   <= rd_ok && pal_valid[entry[IDX_W-1:0]];
    end
  end

  // Form the result beat
  always_comb begin
    q_in.rect_x      = pss_pkg::RECT_X_W'(p_x_lo);
    q_in.rect_y      = pss_pkg::RECT_Y_W'(p_y_lo);
    q_in.rect_width  = pss_pkg::SIZE_W'(p_x_end - p_x_lo);
    q_in.rect_height = pss_pkg::SIZE_W'(p_y_hi - p_y_lo);
    q_in.rect_color  = p_hit ? p_color : pss_pkg::BLANK_COLOR;
  end

  // Result buffer payload
  always_ff @(posedge clk) begin
    if (p_valid) begin
      q_mem[q_tail] <= q_in;
    end
  end

  // Advance buffer pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      q_head  <= '0;
      q_tail  <= '0;
      q_count <= '0;
    end else begin
      if (p_valid) begin
        q_tail <= (q_tail == Q_LAST) ? 2'd0 : q_tail + 2'd1;
      end
      if (rect_fire) begin
        q_head <= (q_head == Q_LAST) ? 2'd0 : q_head + 2'd1;
      end
      if (p_valid && !rect_fire) begin
        q_count <= q_count + 2'd1;
      end else if (!p_valid && rect_fire) begin
        q_count <= q_count - 2'd1;
      end
    end
  end

  assign rect.valid       = q_count != '0;
  assign rect.rect_x      = q_mem[q_head].rect_x;
  assign rect.rect_y      = q_mem[q_head].rect_y;
  assign rect.rect_width  = q_mem[q_head].rect_width;
  assign rect.rect_height = q_mem[q_head].rect_height;
  assign rect.rect_color  = q_mem[q_head].rect_color;

  // Buffer never takes a beat while full unless one leaves in the same cycle
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(p_valid && q_count == Q_FULL && !rect_fire))
    else $error("result buffer overflow");

  // Scale stays within its legal range
  a_scale_range: assert property (@(posedge clk) disable iff (rst)
    scale != '0 && scale <= pss_pkg::MAX_SCALE)
    else $error("scale out of range");

  // Only a character beat can start a rectangle
  a_char_only: assert property (@(posedge clk) disable iff (rst)
    item_fire && cmd != pss_pkg::CMD_CHAR |=> !p_valid)
    else $error("rectangle from non-character beat");

  // Emitted rectangle is non-empty and no larger than the scale
  a_rect_size: assert property (@(posedge clk) disable iff (rst)
    rect.valid |-> rect.rect_width != '0 && rect.rect_height != '0 &&
                   rect.rect_width <= scale && rect.rect_height <= scale)
    else $error("rectangle size out of bounds");

endmodule
